// File: hw/rtl/sprite_and_sample_dma_unit_assert.svh
// Assertion macros used by the checker file of the DMA unit.
`ifndef SPRITE_AND_SAMPLE_DMA_UNIT_ASSERT_SVH
`define SPRITE_AND_SAMPLE_DMA_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SADMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("DMA unit check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SADMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("DMA unit check failed");

`endif

// File: hw/rtl/sadma_pkg.sv
`default_nettype none

package sadma_pkg;

    // Widths of the configuration port.
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // Sprite copy length in bus cycles: one get and one put per byte.
    localparam int SPRITE_BYTES = 256;
    localparam logic [9:0] SPRITE_CYCLES = 10'(2 * SPRITE_BYTES);

    // Bus addresses of interest.
    localparam logic [15:0] ADDR_SPRITE_DMA   = 16'h4014;
    localparam logic [15:0] ADDR_CONFLICT_LO  = 16'h4015;
    localparam logic [15:0] ADDR_CONFLICT_HI  = 16'h4017;
    localparam logic [15:0] SAMPLE_BASE       = 16'h8000;
    localparam logic [15:0] CONFLICT_PAGEMASK = 16'hFFE0;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_ADDRESS = 2'd0,
        REG_LENGTH_BYTES  = 2'd1,
        REG_LOOP_ENABLE   = 2'd2,
        REG_IRQ_ENABLE    = 2'd3
    } sadma_reg_t;

    // Configuration register contents.
    typedef struct packed {
        logic [15:0] start_address;
        logic [11:0] length_bytes;
        logic        loop_enable;
        logic        irq_enable;
    } sadma_cfg_t;

    // One input word.
    typedef struct packed {
        logic        sample_buffer_empty;
        logic        sample_restart;
        logic        halted_before_step;
        logic        halted_after_step;
        logic [15:0] cpu_bus_address;
        logic        cpu_is_write;
        logic [7:0]  bus_data;
        logic [7:0]  sprite_start_index;
    } sadma_in_t;

    // One result word.
    typedef struct packed {
        logic        cpu_ready;
        logic [15:0] effective_address;
        logic        access_granted;
        logic        sprite_write;
        logic [7:0]  sprite_index;
        logic [7:0]  sprite_byte;
        logic        sample_fetch;
        logic [15:0] sample_fetch_address;
        logic        sample_irq_set;
    } sadma_out_t;

endpackage

`default_nettype wire

// File: hw/rtl/sadma_cfg.sv
`default_nettype none

module sadma_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [sadma_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sadma_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output sadma_pkg::sadma_cfg_t                cfg
);
    import sadma_pkg::*;

    sadma_cfg_t cfg_reg;
    sadma_cfg_t cfg_next;

    // Decode one register write.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (sadma_reg_t'(cfg_index))
                REG_START_ADDRESS: cfg_next.start_address = cfg_wdata;
                REG_LENGTH_BYTES:  cfg_next.length_bytes  = cfg_wdata[11:0];
                REG_LOOP_ENABLE:   cfg_next.loop_enable   = cfg_wdata[0];
                REG_IRQ_ENABLE:    cfg_next.irq_enable    = cfg_wdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_address <= 16'hC000;
            cfg_reg.length_bytes  <= 12'd1;
            cfg_reg.loop_enable   <= 1'b0;
            cfg_reg.irq_enable    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hw/rtl/sadma_engine.sv
`default_nettype none

module sadma_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  sadma_pkg::sadma_in_t  item,
    input  sadma_pkg::sadma_cfg_t cfg,
    output sadma_pkg::sadma_out_t res
);
    import sadma_pkg::*;

    // Engine state.
    logic        odd_reg,        odd_next;
    logic        spr_active_reg, spr_active_next;
    logic [9:0]  spr_cycle_reg,  spr_cycle_next;
    logic [15:0] spr_source_reg, spr_source_next;
    logic [7:0]  spr_dest_reg,   spr_dest_next;
    logic        smp_active_reg, smp_active_next;
    logic [1:0]  smp_dummy_reg,  smp_dummy_next;
    logic [15:0] smp_source_reg, smp_source_next;
    logic [15:0] smp_current_reg, smp_current_next;
    logic [11:0] smp_remain_reg, smp_remain_next;

    logic        ready;
    logic        granted;
    logic        fetch;
    logic        spr_run;
    logic [15:0] conflict_addr;

    // Work for one bus cycle: sample restart and arm, engine arbitration, sprite copy, sprite start.
    always_comb
    begin
        odd_next         = ~odd_reg;
        spr_active_next  = spr_active_reg;
        spr_cycle_next   = spr_cycle_reg;
        spr_source_next  = spr_source_reg;
        spr_dest_next    = spr_dest_reg;
        smp_active_next  = smp_active_reg;
        smp_dummy_next   = smp_dummy_reg;
        smp_source_next  = smp_source_reg;
        smp_current_next = smp_current_reg;
        smp_remain_next  = smp_remain_reg;
        res              = '0;
        res.effective_address = item.cpu_bus_address;
        granted          = 1'b1;
        fetch            = 1'b1;
        spr_run          = 1'b0;

        // Restart loads the sample pointer and count.
        if (item.sample_restart)
        begin
            smp_current_next = cfg.start_address | SAMPLE_BASE;
            smp_remain_next  = cfg.length_bytes;
        end

        // Arm the sample engine when the buffer runs dry.
        if (!smp_active_reg && item.sample_buffer_empty && (smp_remain_next != 12'd0))
        begin
            smp_active_next = 1'b1;
            smp_dummy_next  = {1'b0, item.halted_before_step} + 2'd1;
            smp_source_next = smp_current_next;
        end
        if (smp_active_next && (smp_remain_next == 12'd0))
        begin
            smp_active_next = 1'b0;
        end

        ready = !(smp_active_next || spr_active_reg);
        conflict_addr = (item.cpu_bus_address & CONFLICT_PAGEMASK)
                        | {11'd0, smp_source_next[4:0]};

        // Decide who owns the bus this cycle.
        if (ready || !item.halted_after_step)
        begin
            granted = 1'b1;
        end
        else if (smp_active_next)
        begin
            if (smp_dummy_next != 2'd0)
            begin
                smp_dummy_next = smp_dummy_next - 2'd1;
                fetch = 1'b0;
            end
            if (odd_reg)
            begin
                fetch = 1'b0;
            end
            if (!fetch)
            begin
                spr_run = spr_active_reg;
                granted = 1'b1;
            end
            else
            begin
                res.sample_fetch         = 1'b1;
                res.sample_fetch_address = smp_source_next;
                smp_remain_next  = smp_remain_next - 12'd1;
                smp_current_next = {1'b1, smp_current_next[14:0] + 15'd1};
                if (smp_remain_next == 12'd0)
                begin
                    if (cfg.loop_enable)
                    begin
                        smp_current_next = cfg.start_address | SAMPLE_BASE;
                        smp_remain_next  = cfg.length_bytes;
                    end
                    else
                    begin
                        res.sample_irq_set = cfg.irq_enable;
                    end
                end
                smp_active_next = 1'b0;
                if ((conflict_addr >= ADDR_CONFLICT_LO) && (conflict_addr <= ADDR_CONFLICT_HI))
                begin
                    res.effective_address = conflict_addr;
                    granted = 1'b1;
                end
                else
                begin
                    granted = 1'b0;
                end
            end
        end
        else
        begin
            spr_run = 1'b1;
        end

        // One sprite get or put cycle, held off until parity matches.
        if (spr_run)
        begin
            if (odd_reg != spr_cycle_reg[0])
            begin
                granted = 1'b1;
            end
            else
            begin
                if (spr_cycle_reg[0])
                begin
                    res.sprite_write = 1'b1;
                    res.sprite_index = spr_dest_reg;
                    res.sprite_byte  = item.bus_data;
                    spr_dest_next    = spr_dest_reg + 8'd1;
                    granted          = 1'b0;
                end
                else
                begin
                    res.effective_address = spr_source_reg;
                    spr_source_next       = spr_source_reg + 16'd1;
                    granted               = 1'b1;
                end
                spr_cycle_next = spr_cycle_reg + 10'd1;
                if (spr_cycle_next == SPRITE_CYCLES)
                begin
                    spr_active_next = 1'b0;
                end
            end
        end

        // A granted write to the sprite DMA register starts or restarts the copy.
        if (granted && item.cpu_is_write && (res.effective_address == ADDR_SPRITE_DMA))
        begin
            spr_active_next = 1'b1;
            spr_cycle_next  = 10'd0;
            spr_source_next = {item.bus_data, 8'd0};
            spr_dest_next   = item.sprite_start_index;
        end

        res.cpu_ready      = ready;
        res.access_granted = granted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odd_reg         <= 1'b1;
            spr_active_reg  <= 1'b0;
            spr_cycle_reg   <= 10'd0;
            spr_source_reg  <= 16'd0;
            spr_dest_reg    <= 8'd0;
            smp_active_reg  <= 1'b0;
            smp_dummy_reg   <= 2'd0;
            smp_source_reg  <= 16'd0;
            smp_current_reg <= 16'hC000;
            smp_remain_reg  <= 12'd0;
        end
        else if (step)
        begin
            odd_reg         <= odd_next;
            spr_active_reg  <= spr_active_next;
            spr_cycle_reg   <= spr_cycle_next;
            spr_source_reg  <= spr_source_next;
            spr_dest_reg    <= spr_dest_next;
            smp_active_reg  <= smp_active_next;
            smp_dummy_reg   <= smp_dummy_next;
            smp_source_reg  <= smp_source_next;
            smp_current_reg <= smp_current_next;
            smp_remain_reg  <= smp_remain_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sprite_and_sample_dma_unit.sv
`default_nettype none

// Sprite and sample DMA controller, evaluated once per CPU bus cycle. Each input
// word describes one bus cycle; each produces exactly one result word with the
// ready line, the effective bus address, the access grant and any sprite memory
// write or sample fetch. One word is taken every clock unless in_stall is high;
// a word is registered at the input, worked through the engine logic and
// registered at the output. While a result waits there, an empty input register
// still takes a new word. Configuration registers are written through cfg_we,
// cfg_index and cfg_wdata (0 start address, 1 length, 2 loop enable, 3 interrupt
// enable), by the user only while idle; the block does not enforce this.
module sprite_and_sample_dma_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // Input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        sample_buffer_empty,
    input  logic        sample_restart,
    input  logic        halted_before_step,
    input  logic        halted_after_step,
    input  logic [15:0] cpu_bus_address,
    input  logic        cpu_is_write,
    input  logic [7:0]  bus_data,
    input  logic [7:0]  sprite_start_index,
    // Output channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic        cpu_ready,
    output logic [15:0] effective_address,
    output logic        access_granted,
    output logic        sprite_write,
    output logic [7:0]  sprite_index,
    output logic [7:0]  sprite_byte,
    output logic        sample_fetch,
    output logic [15:0] sample_fetch_address,
    output logic        sample_irq_set
);
    import sadma_pkg::*;

    sadma_cfg_t cfg;
    sadma_in_t  item_reg;
    sadma_out_t res;
    sadma_out_t res_reg;
    logic       in_valid_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       step;

    // Configuration registers.
    sadma_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Pipeline flow: the output register frees up when empty or taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    // Engine logic and state.
    sadma_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg.sample_buffer_empty <= sample_buffer_empty;
            item_reg.sample_restart      <= sample_restart;
            item_reg.halted_before_step  <= halted_before_step;
            item_reg.halted_after_step   <= halted_after_step;
            item_reg.cpu_bus_address     <= cpu_bus_address;
            item_reg.cpu_is_write        <= cpu_is_write;
            item_reg.bus_data            <= bus_data;
            item_reg.sprite_start_index  <= sprite_start_index;
        end
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid            = out_valid_reg;
    assign cpu_ready            = res_reg.cpu_ready;
    assign effective_address    = res_reg.effective_address;
    assign access_granted       = res_reg.access_granted;
    assign sprite_write         = res_reg.sprite_write;
    assign sprite_index         = res_reg.sprite_index;
    assign sprite_byte          = res_reg.sprite_byte;
    assign sample_fetch         = res_reg.sample_fetch;
    assign sample_fetch_address = res_reg.sample_fetch_address;
    assign sample_irq_set       = res_reg.sample_irq_set;

endmodule

`default_nettype wire

// File: hw/rtl/sadma_checker.sv
`default_nettype none

`include "sprite_and_sample_dma_unit_assert.svh"

module sadma_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        sample_buffer_empty,
    input  logic        sample_restart,
    input  logic        halted_before_step,
    input  logic        halted_after_step,
    input  logic [15:0] cpu_bus_address,
    input  logic        cpu_is_write,
    input  logic [7:0]  bus_data,
    input  logic [7:0]  sprite_start_index,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        cpu_ready,
    input  logic [15:0] effective_address,
    input  logic        access_granted,
    input  logic        sprite_write,
    input  logic [7:0]  sprite_index,
    input  logic [7:0]  sprite_byte,
    input  logic        sample_fetch,
    input  logic [15:0] sample_fetch_address,
    input  logic        sample_irq_set
);

    // A stalled result word stays put.
    `SADMA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(effective_address) && $stable(sprite_write) && $stable(sample_fetch))

    // A sprite put takes the bus away from the CPU.
    `SADMA_ASSERT_NOW(a_put_blocks, clk, rst_n, out_valid && sprite_write, !cpu_ready && !access_granted && !sample_fetch)

    // Sample fetches only happen with the CPU halted and stay in the upper half.
    `SADMA_ASSERT_NOW(a_fetch_range, clk, rst_n, out_valid && sample_fetch, !cpu_ready && sample_fetch_address[15])

    // The interrupt is raised only by the fetch that ends the sample.
    `SADMA_ASSERT_NOW(a_irq_on_fetch, clk, rst_n, out_valid && sample_irq_set, sample_fetch)

endmodule

bind sprite_and_sample_dma_unit sadma_checker u_sadma_checker (.*);

`default_nettype wire

// File: test/sprite_and_sample_dma_unit_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the DMA unit. Every accepted input word is run
// through a cycle-accurate model of the two engines, and the predicted result
// word is queued. Every accepted result word is compared field by field with
// the oldest prediction.
module sprite_and_sample_dma_unit_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_wdata,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  sadma_pkg::sadma_in_t  in_word,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  sadma_pkg::sadma_out_t result_word,
    output int                    mismatches,
    output int                    pending
);
    import sadma_pkg::*;

    // Model copy of the configuration registers.
    sadma_cfg_t  cfg;

    // Model copy of the engine state.
    logic        odd_cycle;
    logic        spr_busy;
    logic [9:0]  spr_count;
    logic [15:0] spr_src;
    logic [7:0]  spr_dest;
    logic        smp_busy;
    logic [1:0]  smp_dummy;
    logic [15:0] smp_src;
    logic [15:0] smp_cur;
    logic [11:0] smp_left;

    // Result of the bus cycle being predicted, and the words still to come.
    sadma_out_t  cycle_result;
    sadma_out_t  predicted_results[$];
    sadma_out_t  want;

    // One sprite copy cycle: a get on even copy cycles, a put on odd ones.
    // The copy waits while the bus parity does not match. Returns the grant.
    function automatic logic sprite_copy_step(input logic [7:0] data);
        logic put;
        put = spr_count[0];
        if (odd_cycle != put)
            return 1'b1;
        if (put)
        begin
            cycle_result.sprite_write = 1'b1;
            cycle_result.sprite_index = spr_dest;
            cycle_result.sprite_byte = data;
            spr_dest = spr_dest + 8'd1;
        end
        else
        begin
            cycle_result.effective_address = spr_src;
            spr_src = spr_src + 16'd1;
        end
        spr_count = spr_count + 10'd1;
        if (spr_count == SPRITE_CYCLES)
            spr_busy = 1'b0;
        return !put;
    endfunction

    // Work out the result of one bus cycle and queue it.
    task automatic predict_bus_cycle(input sadma_in_t w);
        logic        granted;
        logic        fetch;
        logic [15:0] conflict;

        cycle_result = '0;
        cycle_result.effective_address = w.cpu_bus_address;

        // Restart first, then arming, then cancel on an empty count.
        if (w.sample_restart)
        begin
            smp_cur = cfg.start_address | SAMPLE_BASE;
            smp_left = cfg.length_bytes;
        end
        if (!smp_busy && w.sample_buffer_empty && smp_left != 12'd0)
        begin
            smp_busy = 1'b1;
            smp_dummy = 2'd1 + 2'(w.halted_before_step);
            smp_src = smp_cur;
        end
        if (smp_busy && smp_left == 12'd0)
            smp_busy = 1'b0;

        cycle_result.cpu_ready = !(smp_busy || spr_busy);
        if (cycle_result.cpu_ready || !w.halted_after_step)
            granted = 1'b1;
        else if (smp_busy)
        begin
            // The sample engine owns the cycle; its dummy and realign cycles
            // go to the sprite engine.
            fetch = 1'b1;
            if (smp_dummy != 2'd0)
            begin
                smp_dummy = smp_dummy - 2'd1;
                fetch = 1'b0;
            end
            if (odd_cycle)
                fetch = 1'b0;
            if (!fetch)
                granted = spr_busy ? sprite_copy_step(w.bus_data) : 1'b1;
            else
            begin
                cycle_result.sample_fetch = 1'b1;
                cycle_result.sample_fetch_address = smp_src;
                smp_left = smp_left - 12'd1;
                smp_cur = SAMPLE_BASE + ((smp_cur + 16'd1) & 16'h7FFF);
                if (smp_left == 12'd0)
                begin
                    if (cfg.loop_enable)
                    begin
                        smp_cur = cfg.start_address | SAMPLE_BASE;
                        smp_left = cfg.length_bytes;
                    end
                    else
                        cycle_result.sample_irq_set = cfg.irq_enable;
                end
                smp_busy = 1'b0;
                // A fetch that lands on the APU status page shows up there.
                conflict = (w.cpu_bus_address & CONFLICT_PAGEMASK) | (smp_src & 16'h001F);
                if (conflict >= ADDR_CONFLICT_LO && conflict <= ADDR_CONFLICT_HI)
                begin
                    cycle_result.effective_address = conflict;
                    granted = 1'b1;
                end
                else
                    granted = 1'b0;
            end
        end
        else
            granted = sprite_copy_step(w.bus_data);
        cycle_result.access_granted = granted;

        // A granted write to the sprite DMA register (re)starts the copy.
        if (granted && w.cpu_is_write && cycle_result.effective_address == ADDR_SPRITE_DMA)
        begin
            spr_busy = 1'b1;
            spr_count = '0;
            spr_src = {w.bus_data, 8'h00};
            spr_dest = w.sprite_start_index;
        end

        odd_cycle = !odd_cycle;
        predicted_results.push_back(cycle_result);
    endtask

    task automatic compare_field(input string name, input logic [15:0] expected_value,
                                 input logic [15:0] actual_value);
        if (expected_value !== actual_value)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, expected_value, actual_value);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.start_address = 16'hC000;
            cfg.length_bytes = 12'd1;
            cfg.loop_enable = 1'b0;
            cfg.irq_enable = 1'b0;
            odd_cycle = 1'b1;
            spr_busy = 1'b0;
            spr_count = '0;
            spr_src = '0;
            spr_dest = '0;
            smp_busy = 1'b0;
            smp_dummy = '0;
            smp_src = '0;
            smp_cur = 16'hC000;
            smp_left = '0;
            predicted_results.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (sadma_reg_t'(cfg_index))
                    REG_START_ADDRESS: cfg.start_address = cfg_wdata;
                    REG_LENGTH_BYTES:  cfg.length_bytes = cfg_wdata[11:0];
                    REG_LOOP_ENABLE:   cfg.loop_enable = cfg_wdata[0];
                    REG_IRQ_ENABLE:    cfg.irq_enable = cfg_wdata[0];
                endcase
            end

            // Results are checked before this edge's input word is queued,
            // since no result can belong to a word accepted at the same edge.
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word with nothing expected, address %h",
                             $time, result_word.effective_address);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    compare_field("cpu_ready", 16'(want.cpu_ready),
                                  16'(result_word.cpu_ready));
                    compare_field("effective_address", want.effective_address,
                                  result_word.effective_address);
                    compare_field("access_granted", 16'(want.access_granted),
                                  16'(result_word.access_granted));
                    compare_field("sprite_write", 16'(want.sprite_write),
                                  16'(result_word.sprite_write));
                    compare_field("sprite_index", 16'(want.sprite_index),
                                  16'(result_word.sprite_index));
                    compare_field("sprite_byte", 16'(want.sprite_byte),
                                  16'(result_word.sprite_byte));
                    compare_field("sample_fetch", 16'(want.sample_fetch),
                                  16'(result_word.sample_fetch));
                    compare_field("sample_fetch_address", want.sample_fetch_address,
                                  result_word.sample_fetch_address);
                    compare_field("sample_irq_set", 16'(want.sample_irq_set),
                                  16'(result_word.sample_irq_set));
                end
            end

            if (in_valid && !in_stall)
                predict_bus_cycle(in_word);

            pending <= predicted_results.size();
        end
    end

endmodule

// File: test/sprite_and_sample_dma_unit_tb.sv
`timescale 1ns / 100ps

module sprite_and_sample_dma_unit_tb;

    import sadma_pkg::*;

    localparam int DIRECTED_WORDS  = 25;
    localparam int RANDOM_PHASES   = 5;
    localparam int WORDS_PER_PHASE = 110;
    localparam int SETTLE_CYCLES   = 4;
    localparam int FULL_COPY_HALT  = 540;

    // Idling modes of the two channels.
    localparam int MODE_NONE     = 0;
    localparam int MODE_SENDER   = 1;
    localparam int MODE_RECEIVER = 2;
    localparam int MODE_BOTH     = 3;
    localparam int MODE_COUNT    = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_START_ADDRESS;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    sadma_in_t   in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;

    logic        cpu_ready;
    logic [15:0] effective_address;
    logic        access_granted;
    logic        sprite_write;
    logic [7:0]  sprite_index;
    logic [7:0]  sprite_byte;
    logic        sample_fetch;
    logic [15:0] sample_fetch_address;
    logic        sample_irq_set;
    sadma_out_t  result_word;

    int          mismatches;
    int          pending;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    // Stimulus shaping: cycles left in which the CPU is mostly halted.
    int          halt_run = 0;
    bit          full_copy_seen = 1'b0;

    always #10 clk = ~clk;

    // Receiver side stalls at random, independent of out_valid.
    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    assign result_word = {cpu_ready, effective_address, access_granted, sprite_write,
                          sprite_index, sprite_byte, sample_fetch, sample_fetch_address,
                          sample_irq_set};

    sprite_and_sample_dma_unit dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .sample_buffer_empty  (in_word.sample_buffer_empty),
        .sample_restart       (in_word.sample_restart),
        .halted_before_step   (in_word.halted_before_step),
        .halted_after_step    (in_word.halted_after_step),
        .cpu_bus_address      (in_word.cpu_bus_address),
        .cpu_is_write         (in_word.cpu_is_write),
        .bus_data             (in_word.bus_data),
        .sprite_start_index   (in_word.sprite_start_index),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .cpu_ready            (cpu_ready),
        .effective_address    (effective_address),
        .access_granted       (access_granted),
        .sprite_write         (sprite_write),
        .sprite_index         (sprite_index),
        .sprite_byte          (sprite_byte),
        .sample_fetch         (sample_fetch),
        .sample_fetch_address (sample_fetch_address),
        .sample_irq_set       (sample_irq_set)
    );

    sprite_and_sample_dma_unit_checker bus_cycle_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_word     (in_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_word (result_word),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    task automatic set_idle_mode(input int mode);
        case (mode)
            MODE_SENDER:
            begin
                send_idle_pct = 85;
                stall_pct <= 0;
            end
            MODE_RECEIVER:
            begin
                send_idle_pct = 0;
                stall_pct <= 85;
            end
            MODE_BOTH:
            begin
                send_idle_pct = 37;
                stall_pct <= 37;
            end
            default:
            begin
                send_idle_pct = 0;
                stall_pct <= 0;
            end
        endcase
    endtask

    // Writes all four sample registers on consecutive edges.
    task automatic program_sample(input logic [15:0] start, input logic [15:0] length,
                                  input logic loop_on, input logic irq_on);
        cfg_we <= 1'b1;
        cfg_index <= REG_START_ADDRESS;
        cfg_wdata <= start;
        @(posedge clk);
        cfg_index <= REG_LENGTH_BYTES;
        cfg_wdata <= length;
        @(posedge clk);
        cfg_index <= REG_LOOP_ENABLE;
        cfg_wdata <= 16'(loop_on);
        @(posedge clk);
        cfg_index <= REG_IRQ_ENABLE;
        cfg_wdata <= 16'(irq_on);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offers one word, with a random idle gap ahead of it, and returns at the
    // edge where it is taken. Valid stays high when the next word follows.
    task automatic send_word(input sadma_in_t w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_word <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Lets every outstanding result arrive so that the block is idle.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random bus cycle. A write to the sprite DMA register, or at random an empty
    // sample buffer, is followed by a run of mostly halted cycles so that the engines
    // can make progress; the first copy gets a run long enough to finish.
    task automatic make_random_word(output sadma_in_t w);
        int pick;
        w.sample_restart = ($urandom_range(99) < 3);
        w.sample_buffer_empty = ($urandom_range(99) < 30);
        pick = $urandom_range(99);
        if (pick < 8)
            w.cpu_bus_address = ADDR_SPRITE_DMA;
        else if (pick < 25)
            w.cpu_bus_address = 16'h4000 | 16'($urandom_range(31));
        else if (pick < 45)
            w.cpu_bus_address = SAMPLE_BASE | 16'($urandom_range(16'h7FFF));
        else
            w.cpu_bus_address = 16'($urandom);
        w.cpu_is_write = 1'($urandom_range(1));
        w.bus_data = 8'($urandom);
        w.sprite_start_index = 8'($urandom);
        if (halt_run > 0)
        begin
            halt_run--;
            w.halted_after_step = ($urandom_range(99) < 97);
            w.halted_before_step = ($urandom_range(99) < 90);
        end
        else
        begin
            w.halted_after_step = ($urandom_range(99) < 20);
            w.halted_before_step = ($urandom_range(99) < 20);
            if (w.sample_buffer_empty && $urandom_range(1))
                halt_run = $urandom_range(8, 3);
            if (w.cpu_bus_address == ADDR_SPRITE_DMA && w.cpu_is_write)
            begin
                // Not halted, so the write is granted and starts the copy.
                w.halted_after_step = 1'b0;
                if (!full_copy_seen)
                begin
                    full_copy_seen = 1'b1;
                    halt_run = FULL_COPY_HALT;
                end
                else
                    halt_run = $urandom_range(90, 10);
            end
        end
    endtask

    initial
    begin
        sadma_in_t w;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: sample fetches that hit the status page, a copy that
        // wraps the sprite index and is restarted, and both engines at once.
        set_idle_mode(MODE_NONE);
        program_sample(16'hC016, 16'd2, 1'b0, 1'b1);
        for (int k = 0; k < DIRECTED_WORDS; k++)
        begin
            w = '0;
            w.cpu_bus_address = 16'h4000;
            w.halted_before_step = 1'b1;
            w.halted_after_step = 1'b1;
            case (k)
                // A read of the sprite DMA register starts nothing.
                0:
                begin
                    w.cpu_bus_address = ADDR_SPRITE_DMA;
                    w.halted_before_step = 1'b0;
                    w.halted_after_step = 1'b0;
                end
                1:
                begin
                    w.sample_restart = 1'b1;
                    w.halted_before_step = 1'b0;
                    w.halted_after_step = 1'b0;
                end
                // Armed while already halted: the dummy count takes its larger value.
                2:
                    w.sample_buffer_empty = 1'b1;
                // Armed while running: the smaller dummy count, then the last byte.
                6:
                begin
                    w.sample_buffer_empty = 1'b1;
                    w.halted_before_step = 1'b0;
                end
                9, 18:
                begin
                    w.cpu_bus_address = ADDR_SPRITE_DMA;
                    w.cpu_is_write = 1'b1;
                    w.halted_after_step = 1'b0;
                    w.bus_data = (k == 9) ? 8'hFF : 8'h00;
                    w.sprite_start_index = (k == 9) ? 8'hFF : 8'h00;
                end
                19:
                begin
                    w.sample_restart = 1'b1;
                    w.sample_buffer_empty = 1'b1;
                    w.cpu_bus_address = 16'hFFFF;
                    w.cpu_is_write = 1'b1;
                    w.bus_data = 8'hA5;
                end
                default:
                begin
                    w.sample_buffer_empty = (k > 19);
                    w.bus_data = {8{k[0]}};
                end
            endcase
            send_word(w);
        end
        drain();

        // Random part, one register setting and one idling mode per phase.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_idle_mode(p % MODE_COUNT);
            case (p)
                0: program_sample(SAMPLE_BASE, 16'd1, 1'b0, 1'b1);
                1: program_sample(16'hFFFF, 16'd4081, 1'b1, 1'b0);
                2: program_sample((16'($urandom) & CONFLICT_PAGEMASK)
                                  | 16'($urandom_range(16'h17, 16'h15)),
                                  16'($urandom_range(6, 1)), 1'($urandom_range(1)), 1'b1);
                3: program_sample(16'h0000, 16'd0, 1'b1, 1'b1);
                default: program_sample(SAMPLE_BASE | 16'($urandom_range(16'h7FFF)),
                                        16'($urandom_range(3, 1)), 1'b0, 1'b0);
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                make_random_word(w);
                send_word(w);
            end
            drain();
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/sadma_pkg.sv
hw/rtl/sadma_cfg.sv
hw/rtl/sadma_engine.sv
hw/rtl/sprite_and_sample_dma_unit.sv
hw/rtl/sadma_checker.sv
test/sprite_and_sample_dma_unit_checker.sv
test/sprite_and_sample_dma_unit_tb.sv
